### sv/cmae_pkg.sv
package cmae_pkg;

  localparam int MODELS     = 8;
  localparam int MODEL_BITS = $clog2(MODELS);
  localparam int SLOT_BITS  = 18;
  localparam int HASH_BITS  = 16;
  localparam int COUNT_BITS = 24;
  localparam int TAG_BITS   = 8;
  localparam int ADDR_BITS  = MODEL_BITS + SLOT_BITS;
  localparam int DEPTH      = 1 << ADDR_BITS;

  // register map, byte address = 8 * index
  localparam logic [1:0] REG_MODEL_COUNT   = 2'd0;
  localparam logic [1:0] REG_MODEL_WEIGHTS = 2'd1;
  localparam logic [1:0] REG_MODEL_MASKS   = 2'd2;
  localparam logic [1:0] REG_OUTPUT_LIMIT  = 2'd3;

  localparam logic [7:0] FLUSH_PAD_LIMIT = 8'hc3;

  // one counter table entry: run tag, counter pair, context key
  typedef struct packed {
    logic [TAG_BITS-1:0] tag;
    logic [15:0]         pair;
    logic [31:0]         key;
  } entry_t;

  // saturating count for the coded bit, halving for the other one
  function automatic logic [15:0] pair_update(input logic [15:0] p, input logic y);
    logic [7:0] c0;
    logic [7:0] c1;
    c0 = p[7:0];
    c1 = p[15:8];
    if (y) begin
      if (c1 != 8'hff) c1 = c1 + 8'd1;
      if (c0 > 8'd2) c0 = (c0 >> 1) + 8'd1;
    end else begin
      if (c0 != 8'hff) c0 = c0 + 8'd1;
      if (c1 > 8'd2) c1 = (c1 >> 1) + 8'd1;
    end
    return {c1, c0};
  endfunction

  // context from the history bytes picked by the mask, newer selected bytes above older ones
  function automatic logic [31:0] ctx_key(input logic [7:0] mask,
                                          input logic [7:0][7:0] hist);
    logic [31:0] k;
    k = 32'd0;
    for (int i = 0; i < 8; i++) begin
      if (mask[i]) k = {k[23:0], hist[i]};
    end
    return k;
  endfunction

  // first probe slot of a key
  function automatic logic [SLOT_BITS-1:0] first_slot(input logic [31:0] key);
    logic [31:0] h;
    h = 32'(key[HASH_BITS-1:0]) ^ (key >> HASH_BITS);
    return SLOT_BITS'(h << 2);
  endfunction

endpackage

### sv/context_mixing_arith_encoder.sv
// Context-mixing binary arithmetic encoder.
// Input channel: data_byte/final_byte with in_valid/in_stall; a byte is taken
// when in_valid is high and in_stall low. Only one byte is in work at a time.
// Output channel: code_byte, run_end, stream_done, overflow with out_valid /
// out_stall. A byte gives zero or more code bytes; run_end marks the last one.
// Each byte codes 8 bits. Per bit with N models in use the steps are the counter
// reads of each model, a multiply, a 32-bit quotient from the radix-2 divider,
// an update, then per model a write-back and one or more table probes, and
// last the settled code bytes are shifted out.
// All counters live in one single-port-write, one-read table memory of
// 2^21 entries, which bounds the model loop to one access per cycle.
// Reset: a clearing pass writes all 2^21 entries of the table; the same pass
// repeats after every 255 streams when the run tag wraps. No byte is taken
// during the pass; configuration writes are taken at any time.
// A stalled receiver holds the output register; one more result is kept in a
// pending stage and the sequencer waits when both are full.
module context_mixing_arith_encoder
  import cmae_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  data_byte,
  input  logic        final_byte,
  input  logic        in_valid,
  output logic        in_stall,
  output logic [7:0]  code_byte,
  output logic        run_end,
  output logic        stream_done,
  output logic        overflow,
  output logic        out_valid,
  input  logic        out_stall,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_RD_A  = 4'd2;
  localparam logic [3:0] ST_RD_D  = 4'd3;
  localparam logic [3:0] ST_MUL   = 4'd4;
  localparam logic [3:0] ST_DIV   = 4'd5;
  localparam logic [3:0] ST_UPD   = 4'd6;
  localparam logic [3:0] ST_WB    = 4'd7;
  localparam logic [3:0] ST_PR_A  = 4'd8;
  localparam logic [3:0] ST_PR_D  = 4'd9;
  localparam logic [3:0] ST_SHIFT = 4'd10;
  localparam logic [3:0] ST_FL1   = 4'd11;
  localparam logic [3:0] ST_FL2   = 4'd12;
  localparam logic [3:0] ST_FAIL  = 4'd13;
  localparam logic [3:0] ST_END   = 4'd14;

  // configuration
  logic [3:0]            model_count;
  logic [63:0]           model_weights;
  logic [63:0]           model_masks;
  logic [COUNT_BITS-1:0] output_limit;

  // coder state
  logic [3:0]            state;
  logic [31:0]           range_low;
  logic [31:0]           range_high;
  logic [7:0][7:0]       hist;
  logic [SLOT_BITS-1:0]  cur_slot [MODELS];
  logic [15:0]           start_cnt [MODELS];
  logic [15:0]           pair_q [MODELS];
  logic                  valid_q [MODELS];
  logic [31:0]           ekey_q [MODELS];
  logic [COUNT_BITS-1:0] bytes_out;
  logic                  at_start;
  logic                  overflow_seen;
  logic [TAG_BITS-1:0]   run_tag;
  logic [ADDR_BITS-1:0]  clr_addr;

  // per transaction work registers
  logic [7:0]            byte_q;
  logic                  fin_q;
  logic [2:0]            bit_i;
  logic [3:0]            mcnt;
  logic [19:0]           n0;
  logic [19:0]           n1;
  logic [20:0]           dsr;
  logic [20:0]           rem;
  logic [31:0]           dq;
  logic [4:0]            div_cnt;
  logic [31:0]           key_q;
  logic [SLOT_BITS-1:0]  probe_slot;
  logic [SLOT_BITS-1:0]  probe_cnt;

  // output register and pending result
  logic [7:0]            pend_code;
  logic                  pend_ovf;
  logic                  pend_valid;

  // table memory
  entry_t                mem [DEPTH];
  entry_t                rd_data;
  logic                  mem_we;
  logic [ADDR_BITS-1:0]  mem_wa;
  entry_t                mem_wd;
  logic [ADDR_BITS-1:0]  mem_ra;

  // derived
  logic [3:0]            nm;
  logic [MODEL_BITS-1:0] midx;
  logic                  y;
  logic [7:0]            w_m;
  logic [7:0]            mask_m;
  logic [15:0]           rd_pair;
  logic                  rd_ok;
  logic [15:0]           new_pair;
  logic [31:0]           new_key;
  logic [51:0]           prod;
  logic [21:0]           div_t;
  logic                  div_ge;
  logic [31:0]           xmid;
  logic [7:0]            h0_next;
  logic [COUNT_BITS-1:0] bytes_next;
  logic                  limit_hit;
  logic                  settle;
  logic                  out_free;
  logic                  can_push;
  logic                  push_en;
  logic [7:0]            push_code;
  logic                  push_ovf;
  logic                  end_move;

  assign nm       = (model_count > 4'(MODELS)) ? 4'(MODELS) : model_count;
  assign midx     = (state == ST_RD_A || state == ST_RD_D) ? mcnt[MODEL_BITS-1:0]
                                                            : MODEL_BITS'(mcnt - 4'd1);
  assign y        = byte_q[3'd7 - bit_i];
  assign w_m      = model_weights[{midx, 3'b000} +: 8];
  assign mask_m   = model_masks[{midx, 3'b000} +: 8];
  assign rd_ok    = (rd_data.tag == run_tag);
  assign rd_pair  = at_start ? start_cnt[midx] : (rd_ok ? rd_data.pair : 16'd0);
  assign new_pair = pair_update(pair_q[midx], y);
  assign new_key  = ctx_key(mask_m, hist);
  assign prod     = 52'(n0) * 52'(range_high - range_low);
  assign div_t    = {rem, dq[31]};
  assign div_ge   = (div_t >= 22'(dsr));
  assign xmid     = range_low + dq;
  assign h0_next  = {hist[0][6:0], y};
  assign bytes_next = bytes_out + COUNT_BITS'(1);
  assign limit_hit  = (bytes_next >= output_limit);
  assign settle     = ((range_low ^ range_high) & 32'hff000000) == 32'd0;
  assign out_free   = !out_valid || !out_stall;
  assign can_push   = !pend_valid || out_free;
  assign in_stall   = (state != ST_IDLE);
  assign pready     = 1'b1;

  // configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      model_count   <= 4'd2;
      model_weights <= 64'd264;
      model_masks   <= 64'd259;
      output_limit  <= COUNT_BITS'(65536);
    end else if (psel && penable && pwrite) begin
      case (paddr[4:3])
        REG_MODEL_COUNT:   model_count   <= pwdata[3:0];
        REG_MODEL_WEIGHTS: model_weights <= pwdata;
        REG_MODEL_MASKS:   model_masks   <= pwdata;
        REG_OUTPUT_LIMIT:  output_limit  <= pwdata[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      REG_MODEL_COUNT:   prdata = 64'(model_count);
      REG_MODEL_WEIGHTS: prdata = model_weights;
      REG_MODEL_MASKS:   prdata = model_masks;
      REG_OUTPUT_LIMIT:  prdata = 64'(output_limit);
      default:           prdata = 64'd0;
    endcase
  end

  // table memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_data <= mem[mem_ra];
  end

  // memory access and result pushes per state
  always_comb begin
    mem_we    = 1'b0;
    mem_wa    = {midx, probe_slot};
    mem_wd    = '{tag: run_tag, pair: 16'd0, key: key_q};
    mem_ra    = {midx, probe_slot};
    push_en   = 1'b0;
    push_code = 8'd0;
    push_ovf  = 1'b0;
    end_move  = 1'b0;
    case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_addr;
        mem_wd = '{tag: '0, pair: 16'd0, key: 32'd0};
      end
      ST_IDLE: begin
        push_en  = in_valid && overflow_seen && final_byte;
        push_ovf = 1'b1;
      end
      ST_RD_A: mem_ra = {midx, cur_slot[midx]};
      ST_WB: begin
        mem_we = !at_start && valid_q[midx];
        mem_wa = {midx, cur_slot[midx]};
        mem_wd = '{tag: run_tag, pair: new_pair, key: ekey_q[midx]};
      end
      ST_PR_D: mem_we = !rd_ok;
      ST_SHIFT: begin
        push_en   = settle && can_push;
        push_code = range_high[31:24];
        push_ovf  = limit_hit;
      end
      ST_FL1: begin
        push_en   = can_push;
        push_code = range_high[31:24];
        push_ovf  = (range_high[23:16] < FLUSH_PAD_LIMIT) && limit_hit;
      end
      ST_FL2:  push_en = can_push;
      ST_FAIL: begin
        push_en  = can_push;
        push_ovf = 1'b1;
      end
      ST_END:  end_move = pend_valid && out_free;
      default: ;
    endcase
  end

  // output register and pending stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (push_en) begin
        if (pend_valid) begin
          out_valid   <= 1'b1;
          code_byte   <= pend_code;
          overflow    <= pend_ovf;
          run_end     <= 1'b0;
          stream_done <= 1'b0;
        end else if (out_valid && !out_stall) begin
          out_valid <= 1'b0;
        end
        pend_valid <= 1'b1;
        pend_code  <= push_code;
        pend_ovf   <= push_ovf;
      end else if (end_move) begin
        out_valid   <= 1'b1;
        code_byte   <= pend_code;
        overflow    <= pend_ovf;
        run_end     <= 1'b1;
        stream_done <= fin_q;
        pend_valid  <= 1'b0;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_addr      <= '0;
      run_tag       <= TAG_BITS'(1);
      range_low     <= 32'd0;
      range_high    <= 32'hffffffff;
      hist          <= {56'd0, 8'd1};
      bytes_out     <= '0;
      at_start      <= 1'b1;
      overflow_seen <= 1'b0;
      for (int i = 0; i < MODELS; i++) begin
        cur_slot[i]  <= '0;
        start_cnt[i] <= 16'd0;
      end
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + ADDR_BITS'(1);
          if (&clr_addr) state <= ST_IDLE;
        end

        ST_IDLE: begin
          if (in_valid) begin
            byte_q <= data_byte;
            fin_q  <= final_byte;
            bit_i  <= 3'd0;
            mcnt   <= 4'd0;
            n0     <= 20'd1;
            n1     <= 20'd1;
            if (overflow_seen) begin
              if (final_byte) state <= ST_END;
            end else begin
              state <= (nm == 4'd0) ? ST_MUL : ST_RD_A;
            end
          end
        end

        ST_RD_A: state <= ST_RD_D;

        // weighted counts of model midx
        ST_RD_D: begin
          pair_q[midx]  <= rd_pair;
          valid_q[midx] <= rd_ok;
          ekey_q[midx]  <= rd_data.key;
          n0 <= n0 + 20'(rd_pair[7:0] * w_m);
          n1 <= n1 + 20'(rd_pair[15:8] * w_m);
          mcnt <= mcnt + 4'd1;
          state <= (mcnt + 4'd1 == nm) ? ST_MUL : ST_RD_A;
        end

        ST_MUL: begin
          rem     <= 21'(prod[51:32]);
          dq      <= prod[31:0];
          dsr     <= 21'(n0) + 21'(n1);
          div_cnt <= 5'd0;
          state   <= ST_DIV;
        end

        // one quotient bit per cycle
        ST_DIV: begin
          rem     <= div_ge ? 21'(div_t - 22'(dsr)) : div_t[20:0];
          dq      <= {dq[30:0], div_ge};
          div_cnt <= div_cnt + 5'd1;
          if (&div_cnt) state <= ST_UPD;
        end

        ST_UPD: begin
          if (y) range_low <= xmid + 32'd1;
          else   range_high <= xmid;
          if (bit_i == 3'd7) hist <= {hist[6:1], h0_next, 8'd1};
          else               hist[0] <= h0_next;
          mcnt <= nm;
          if (nm == 4'd0) begin
            at_start <= 1'b0;
            state    <= ST_SHIFT;
          end else begin
            state <= ST_WB;
          end
        end

        // counter write-back, then start the context lookup
        ST_WB: begin
          if (at_start) start_cnt[midx] <= new_pair;
          key_q      <= new_key;
          probe_slot <= first_slot(new_key);
          probe_cnt  <= '0;
          state      <= ST_PR_A;
        end

        ST_PR_A: state <= ST_PR_D;

        ST_PR_D: begin
          if (!rd_ok || rd_data.key == key_q) begin
            cur_slot[midx] <= probe_slot;
            mcnt <= mcnt - 4'd1;
            if (mcnt == 4'd1) begin
              at_start <= 1'b0;
              state    <= ST_SHIFT;
            end else begin
              state <= ST_WB;
            end
          end else if (&probe_cnt) begin
            state <= ST_FAIL;
          end else begin
            probe_slot <= probe_slot + SLOT_BITS'(1);
            probe_cnt  <= probe_cnt + SLOT_BITS'(1);
            state      <= ST_PR_A;
          end
        end

        // settled top bytes
        ST_SHIFT: begin
          if (settle) begin
            if (can_push) begin
              range_low  <= {range_low[23:0], 8'd0};
              range_high <= {range_high[23:0], 8'hff};
              bytes_out  <= bytes_next;
              if (limit_hit) begin
                overflow_seen <= 1'b1;
                state         <= ST_END;
              end
            end
          end else if (bit_i == 3'd7) begin
            state <= fin_q ? ST_FL1 : ST_END;
          end else begin
            bit_i <= bit_i + 3'd1;
            mcnt  <= 4'd0;
            n0    <= 20'd1;
            n1    <= 20'd1;
            state <= (nm == 4'd0) ? ST_MUL : ST_RD_A;
          end
        end

        ST_FL1: begin
          if (can_push) begin
            bytes_out <= bytes_next;
            if (range_high[23:16] < FLUSH_PAD_LIMIT) begin
              if (limit_hit) begin
                overflow_seen <= 1'b1;
                state         <= ST_END;
              end else begin
                state <= ST_FL2;
              end
            end else begin
              state <= ST_END;
            end
          end
        end

        ST_FL2: begin
          if (can_push) begin
            bytes_out <= bytes_next;
            state     <= ST_END;
          end
        end

        ST_FAIL: begin
          if (can_push) begin
            overflow_seen <= 1'b1;
            state         <= ST_END;
          end
        end

        // last result of the transaction, then a new run on a final byte
        ST_END: begin
          if (!pend_valid || out_free) begin
            if (!fin_q) begin
              state <= ST_IDLE;
            end else begin
              range_low     <= 32'd0;
              range_high    <= 32'hffffffff;
              hist          <= {56'd0, 8'd1};
              bytes_out     <= '0;
              at_start      <= 1'b1;
              overflow_seen <= 1'b0;
              for (int i = 0; i < MODELS; i++) begin
                cur_slot[i]  <= '0;
                start_cnt[i] <= 16'd0;
              end
              if (&run_tag) begin
                run_tag  <= TAG_BITS'(1);
                clr_addr <= '0;
                state    <= ST_CLEAR;
              end else begin
                run_tag <= run_tag + TAG_BITS'(1);
                state   <= ST_IDLE;
              end
            end
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### tb/context_mixing_arith_encoder_tb.sv
module context_mixing_arith_encoder_tb;
  import cmae_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS      = 1 << SLOT_BITS;
  localparam int IDLE_LIMIT = 8_000_000;  // several times the table clearing pass
  localparam int SETTLE     = 1500;       // worst byte with eight models, plus margin
  localparam int HOLD_LEN   = 3000;

  typedef struct {
    logic [7:0] data;
    logic       fin;
  } byte_item_t;

  typedef struct {
    logic [7:0] code;
    logic       last;
    logic       done;
    logic       ovf;
  } code_item_t;

  logic        clk;
  logic        rst;
  logic [7:0]  data_byte;
  logic        final_byte;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  code_byte;
  logic        run_end;
  logic        stream_done;
  logic        overflow;
  logic        out_valid;
  logic        out_stall;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  context_mixing_arith_encoder u_top (.*);

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // pending input bytes and expected code bytes
  byte_item_t byte_q[$];
  code_item_t code_exp[$];
  code_item_t new_codes[$];

  // encoder state mirror
  logic [3:0]  cfg_count;
  logic [63:0] cfg_weights;
  logic [63:0] cfg_masks;
  logic [23:0] cfg_limit;
  logic [31:0] lo, hi;
  logic [7:0]  hist[8];
  logic [SLOT_BITS-1:0] cur_slot[MODELS];
  logic [15:0] start_pair[MODELS];
  logic [23:0] nout;
  logic        at_start;
  logic        failed;
  logic [47:0] ctx_tbl[int];   // {pair, key}, indexed by {model, slot}

  int n_err, n_items, n_codes, n_streams, n_ovf;
  bit quiet;

  function automatic void start_stream();
    lo = '0;
    hi = '1;
    for (int k = 0; k < 8; k++) hist[k] = 8'd0;
    hist[0] = 8'd1;
    for (int m = 0; m < MODELS; m++) begin
      cur_slot[m] = '0;
      start_pair[m] = '0;
    end
    nout = '0;
    at_start = 1'b1;
    failed = 1'b0;
    ctx_tbl.delete();
  endfunction

  function automatic void put_code(logic [7:0] c, logic ovf);
    code_item_t r;
    r.code = c;
    r.last = 1'b0;
    r.done = 1'b0;
    r.ovf  = ovf;
    if (new_codes.size() < 32) new_codes.push_back(r);
  endfunction

  function automatic logic [15:0] get_pair(int m);
    int idx;
    idx = (m << SLOT_BITS) | int'(cur_slot[m]);
    if (at_start) return start_pair[m];
    if (ctx_tbl.exists(idx)) return ctx_tbl[idx][47:32];
    return 16'd0;
  endfunction

  function automatic void set_pair(int m, logic [15:0] p);
    int idx;
    idx = (m << SLOT_BITS) | int'(cur_slot[m]);
    if (at_start) start_pair[m] = p;
    else if (ctx_tbl.exists(idx)) ctx_tbl[idx][47:32] = p;
  endfunction

  function automatic logic [15:0] bump_pair(logic [15:0] p, logic y);
    logic [7:0] hit, miss;
    hit  = y ? p[15:8] : p[7:0];
    miss = y ? p[7:0] : p[15:8];
    if (hit != 8'hff) hit = hit + 8'd1;
    if (miss > 8'd2) miss = (miss >> 1) + 8'd1;
    return y ? {hit, miss} : {miss, hit};
  endfunction

  // find or claim the slot of a context; 0 when the table is full
  function automatic bit find_slot(int m, logic [31:0] key, output logic [SLOT_BITS-1:0] slot);
    logic [31:0] h;
    logic [SLOT_BITS-1:0] s;
    int idx;
    h = {16'd0, key[HASH_BITS-1:0]} ^ (key >> HASH_BITS);
    s = SLOT_BITS'(h << 2);
    slot = '0;
    for (int p = 0; p < SLOTS; p++) begin
      idx = (m << SLOT_BITS) | int'(s);
      if (!ctx_tbl.exists(idx)) begin
        ctx_tbl[idx] = {16'd0, key};
        slot = s;
        return 1'b1;
      end
      if (ctx_tbl[idx][31:0] == key) begin
        slot = s;
        return 1'b1;
      end
      s = s + 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit emit_code(logic [7:0] c);
    put_code(c, 1'b0);
    nout = nout + 1'b1;
    if (nout >= cfg_limit) begin
      new_codes[$].ovf = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit settle_top();
    logic [7:0] top;
    while (((lo ^ hi) & 32'hff000000) == 0) begin
      top = hi[31:24];
      lo = lo << 8;
      hi = (hi << 8) | 32'hff;
      if (emit_code(top)) return 1'b1;
    end
    return 1'b0;
  endfunction

  // 0 ok, 1 output limit, 2 table full
  function automatic int code_bits(logic [7:0] b);
    int nm;
    logic y;
    logic [63:0] n0, n1, w;
    logic [15:0] p;
    logic [31:0] xmid, key;
    logic [7:0] mask;
    logic [SLOT_BITS-1:0] slot;
    nm = cfg_count > MODELS ? MODELS : int'(cfg_count);
    for (int i = 0; i < 8; i++) begin
      y = b[7-i];
      n0 = 64'd1;
      n1 = 64'd1;
      for (int m = 0; m < nm; m++) begin
        p = get_pair(m);
        w = 64'(cfg_weights[8*m +: 8]);
        n0 = n0 + 64'(p[7:0]) * w;
        n1 = n1 + 64'(p[15:8]) * w;
      end
      xmid = lo + 32'(n0 * 64'(hi - lo) / (n0 + n1));
      if (y) lo = xmid + 1; else hi = xmid;
      hist[0] = {hist[0][6:0], y};
      if (i == 7) begin
        for (int k = 7; k > 0; k--) hist[k] = hist[k-1];
        hist[0] = 8'd1;
      end
      for (int m = nm - 1; m >= 0; m--) begin
        mask = cfg_masks[8*m +: 8];
        key = '0;
        set_pair(m, bump_pair(get_pair(m), y));
        for (int k = 0; k < 8; k++)
          if (mask[k]) key = (key << 8) + 32'(hist[k]);
        if (!find_slot(m, key, slot)) return 2;
        cur_slot[m] = slot;
      end
      at_start = 1'b0;
      if (settle_top()) return 1;
    end
    return 0;
  endfunction

  function automatic int flush_coder();
    if (settle_top()) return 1;
    put_code(hi[31:24], 1'b0);
    nout = nout + 1'b1;
    if (hi[23:16] < FLUSH_PAD_LIMIT) begin
      if (nout >= cfg_limit) begin
        new_codes[$].ovf = 1'b1;
        return 1;
      end
      put_code(8'd0, 1'b0);
      nout = nout + 1'b1;
    end
    return 0;
  endfunction

  // expected code bytes for one accepted input byte
  function automatic void encode_byte(byte_item_t it);
    int r;
    new_codes.delete();
    if (failed) begin
      if (it.fin) begin
        put_code(8'd0, 1'b1);
        new_codes[$].done = 1'b1;
        start_stream();
      end
    end else begin
      r = code_bits(it.data);
      if (r == 0 && it.fin) r = flush_coder();
      if (r != 0) begin
        failed = 1'b1;
        if (r == 2) put_code(8'd0, 1'b1);
      end
      if (it.fin) begin
        if (new_codes.size() > 0) new_codes[$].done = 1'b1;
        start_stream();
      end
    end
    if (new_codes.size() > 0) new_codes[$].last = 1'b1;
    foreach (new_codes[k]) code_exp.push_back(new_codes[k]);
  endfunction

  // handshake sampling, result check, watchdog
  logic in_took, out_took;
  int   idle_cycles;
  always @(posedge clk) begin
    code_item_t e;
    in_took  <= in_valid && !in_stall;
    out_took <= out_valid && !out_stall;
    if (!rst && out_valid && !out_stall) begin
      n_codes++;
      if (overflow) n_ovf++;
      if (code_exp.size() == 0) begin
        $error("unexpected code byte %02h", code_byte);
        n_err++;
      end else begin
        e = code_exp.pop_front();
        if (code_byte !== e.code) begin
          $error("code_byte expected %02h got %02h", e.code, code_byte);
          n_err++;
        end
        if (run_end !== e.last) begin
          $error("run_end expected %0b got %0b", e.last, run_end);
          n_err++;
        end
        if (stream_done !== e.done) begin
          $error("stream_done expected %0b got %0b", e.done, stream_done);
          n_err++;
        end
        if (overflow !== e.ovf) begin
          $error("overflow expected %0b got %0b", e.ovf, overflow);
          n_err++;
        end
      end
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
      $display("[context_mixing_arith_encoder] ERROR");
      $finish;
    end
  end

  // input driver
  byte_item_t cur;
  int gap;
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap = 0;
    end else if (!(in_valid && !in_took)) begin
      if (in_valid && in_took) begin
        encode_byte(cur);
        n_items++;
        gap = quiet ? 0 : $urandom_range(0, 3);
      end
      if (gap > 0) begin
        gap--;
        in_valid <= 1'b0;
      end else if (byte_q.size() > 0) begin
        cur = byte_q.pop_front();
        data_byte  <= cur.data;
        final_byte <= cur.fin;
        in_valid   <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output back-pressure, with one long hold to fill the block
  int stall_cnt, hold_cnt;
  bit held;
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_cnt = 0;
      hold_cnt = 0;
    end else begin
      if (out_took) stall_cnt = quiet ? 0 : $urandom_range(0, 3);
      if (!held && n_codes >= 60) begin
        held = 1'b1;
        hold_cnt = HOLD_LEN;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall <= 1'b1;
      end else if (stall_cnt > 0) begin
        stall_cnt--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [63:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_MODEL_COUNT:   cfg_count   = val[3:0];
      REG_MODEL_WEIGHTS: cfg_weights = val;
      REG_MODEL_MASKS:   cfg_masks   = val;
      REG_OUTPUT_LIMIT:  cfg_limit   = val[23:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [3:0] cnt, logic [63:0] w, logic [63:0] m, logic [23:0] lim);
    reg_write(REG_MODEL_COUNT, 64'(cnt));
    reg_write(REG_MODEL_WEIGHTS, w);
    reg_write(REG_MODEL_MASKS, m);
    reg_write(REG_OUTPUT_LIMIT, 64'(lim));
  endtask

  // queue a stream; kind 0 random, 1 few symbols, 2 all zero
  task automatic add_stream(int len, int kind);
    byte_item_t it;
    for (int k = 0; k < len; k++) begin
      case (kind)
        0: it.data = 8'($urandom);
        1: it.data = 8'h61 + 8'($urandom_range(0, 3));
        default: it.data = 8'h00;
      endcase
      it.fin = (k == len - 1);
      byte_q.push_back(it);
    end
    n_streams++;
  endtask

  task automatic add_bytes(logic [7:0] b[$]);
    byte_item_t it;
    foreach (b[k]) begin
      it.data = b[k];
      it.fin  = (k == b.size() - 1);
      byte_q.push_back(it);
    end
    n_streams++;
  endtask

  // wait until the block is idle before touching registers
  task automatic drain();
    while (byte_q.size() > 0 || in_valid || code_exp.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    logic [3:0]  cnt;
    logic [63:0] w, m;
    logic [23:0] lim;
    int nstr;
    rst = 1'b1;
    in_valid = 1'b0;
    data_byte = '0;
    final_byte = 1'b0;
    out_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cfg_count = 4'd2;
    cfg_weights = 64'd264;
    cfg_masks = 64'd259;
    cfg_limit = 24'd65536;
    start_stream();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: widest settings, bit patterns
    set_config(4'd8, '1, '1, 24'hffffff);
    add_bytes('{8'h00, 8'hff, 8'h80, 8'h01, 8'h7f, 8'h55});
    drain();
    // no models at all, then one
    set_config(4'd0, '0, '0, 24'hffffff);
    add_bytes('{8'ha5, 8'h5a});
    drain();
    reg_write(REG_MODEL_COUNT, 64'd1);
    reg_write(REG_MODEL_WEIGHTS, 64'h01);
    add_bytes('{8'hc3, 8'h3c});
    drain();
    // count above the model limit, one history byte per model
    set_config(4'd15, {$urandom, $urandom}, 64'h80402010_08040201, 24'hffffff);
    add_bytes('{8'h10, 8'h20, 8'h10, 8'h20});
    drain();
    // output limit reached at once, later bytes dropped until the final one
    reg_write(REG_OUTPUT_LIMIT, 64'd1);
    add_bytes('{8'h00, 8'h11, 8'h22});
    drain();
    // limit hit inside the flush
    reg_write(REG_MODEL_COUNT, 64'd2);
    reg_write(REG_OUTPUT_LIMIT, 64'd2);
    add_bytes('{8'h42});
    drain();
    reg_write(REG_OUTPUT_LIMIT, 64'd3);
    add_bytes('{8'hf0, 8'h0f});
    drain();

    // random phases
    while (n_items < 160) begin
      cnt = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(2, 8));
      w = {$urandom, $urandom};
      m = ($urandom_range(0, 1) == 0) ? {$urandom, $urandom} : 64'h0101010101010101 << $urandom_range(0, 7);
      lim = ($urandom_range(0, 4) == 0) ? 24'($urandom_range(1, 40)) : 24'hffffff;
      quiet = ($urandom_range(0, 2) == 0);
      set_config(cnt, w, m, lim);
      nstr = $urandom_range(1, 3);
      for (int s = 0; s < nstr; s++) add_stream($urandom_range(1, 25), $urandom_range(0, 1));
      if (n_streams == 15) add_stream(40, 2);   // long zero run saturates counts
      drain();
    end

    $display("covered %0d streams, %0d bytes in, %0d code bytes out (%0d with overflow)",
             n_streams, n_items, n_codes, n_ovf);
    if (n_err == 0) begin
      $display("[context_mixing_arith_encoder] OK");
    end else begin
      $display("[context_mixing_arith_encoder] ERROR");
    end
    $finish;
  end

endmodule
